[rtl/core/cbm_pkg.sv]
// Package for the cartridge bank mapper core: command codes, mirroring modes,
// configuration register indexes and CPU address decode constants.
// No dependencies.
package cbm_pkg;

  // Access commands carried by each input transaction
  typedef enum logic [2:0] {
    CMD_REG_WRITE   = 3'd0,
    CMD_PRG_LOOKUP  = 3'd1,
    CMD_CHR_LOOKUP  = 3'd2,
    CMD_NT_LOOKUP   = 3'd3,
    CMD_LATCH_WRITE = 3'd4,
    CMD_LATCH_READ  = 3'd5
  } cmd_t;

  // Nametable mirroring modes (single-screen modes only on the variant board)
  typedef enum logic [1:0] {
    MIR_VERTICAL    = 2'd0,
    MIR_HORIZONTAL  = 2'd1,
    MIR_SINGLE_LOW  = 2'd2,
    MIR_SINGLE_HIGH = 2'd3
  } mirror_t;

  // Select index codes in the 0x9000 register window
  localparam logic [1:0] SEL_SWAP = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_VARIANT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL0    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEL1    = 2'd2;

  // CPU write decode: top address nibble and the CHR register window
  localparam logic [3:0]  TOP_PRG0      = 4'h8;
  localparam logic [3:0]  TOP_MIRROR    = 4'h9;
  localparam logic [3:0]  TOP_PRG1      = 4'hA;
  localparam logic [15:0] CHR_WIN_BASE  = 16'hB000;
  localparam logic [15:0] CHR_WIN_LAST  = 16'hEFFF;
  localparam logic [7:0]  DATA_NO_MIRROR = 8'hFF;

  // Result field widths
  localparam int unsigned BANK_W   = 9;
  localparam int unsigned OFFSET_W = 13;
  localparam int unsigned CHR_FULL_W = 12;

endpackage

[rtl/core/cartridge_bank_mapper_core.sv]
// Cartridge bank mapper core: register decode, PRG/CHR/nametable translation
// and serial latch. Depends on cbm_pkg.
//
// One access per transaction, one transaction per clock sustained while
// out_stall is low. Each access is captured in an input register, translated by
// a single level of decode and bank selection, and written to the result
// register. Register and latch writes take effect as the access leaves the
// input register, in order with the lookups around them. The input register
// also absorbs one access while a result is held by out_stall, so the input side
// keeps moving until both registers are full. Configuration writes (cfg_index 0:
// variant flag, 1 and 2: CPU address bits used as register selects) are always
// accepted; the user must keep them to idle periods (the block does not check).
module cartridge_bank_mapper_core #(
  parameter int PRG_BANK_BITS = 5,
  parameter int CHR_BANK_BITS = 9
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_cmd,
  input  logic [15:0]                       in_address,
  input  logic [7:0]                        in_data,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cbm_pkg::BANK_W-1:0]        out_bank,
  output logic [cbm_pkg::OFFSET_W-1:0]      out_offset,
  output logic [7:0]                        out_read_data,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [2:0]                        cfg_data
);

  // PRG registers hold 5 data bits; fewer are kept when the bank field is narrower
  localparam int PRG_REG_W = (PRG_BANK_BITS < 5) ? PRG_BANK_BITS : 5;
  localparam logic [cbm_pkg::BANK_W-1:0] PRG_LAST =
    cbm_pkg::BANK_W'((1 << PRG_BANK_BITS) - 1);
  localparam logic [cbm_pkg::BANK_W-1:0] PRG_PENULT =
    PRG_LAST & ~cbm_pkg::BANK_W'(1);

  // Configuration registers
  logic       variant_r;
  logic [2:0] sel0_r;
  logic [2:0] sel1_r;

  // Mapper state
  logic [PRG_REG_W-1:0]     prg_r [2];
  logic [CHR_BANK_BITS-1:0] chr_r [8];
  logic                     swap_r;
  logic [1:0]               mirror_r;
  logic                     latch_r;

  // Input register
  logic               s1_valid_r;
  cbm_pkg::cmd_t      s1_cmd_r;
  logic [15:0]        s1_addr_r;
  logic [7:0]         s1_data_r;

  // Result register
  logic                         out_valid_r;
  logic [cbm_pkg::BANK_W-1:0]   out_bank_r;
  logic [cbm_pkg::OFFSET_W-1:0] out_offset_r;
  logic [7:0]                   out_rdata_r;

  // Handshake
  logic s1_adv;
  logic s1_fire;

  assign s1_adv    = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign cfg_ready = 1'b1;

  assign out_valid     = out_valid_r;
  assign out_bank      = out_bank_r;
  assign out_offset    = out_offset_r;
  assign out_read_data = out_rdata_r;

  // Configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= 1'b0;
      sel0_r    <= 3'd0;
      sel1_r    <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cbm_pkg::CFG_VARIANT: variant_r <= cfg_data[0];
        cbm_pkg::CFG_SEL0:    sel0_r    <= cfg_data;
        cbm_pkg::CFG_SEL1:    sel1_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd_r  <= cbm_pkg::cmd_t'(in_cmd);
      s1_addr_r <= in_address;
      s1_data_r <= in_data;
    end
  end

  // Register write decode
  logic [3:0]  top;
  logic [7:0]  sel_byte;
  logic        s0;
  logic        s1;
  logic [1:0]  mir_sel;
  logic [15:0] chr_rel;
  logic [2:0]  chr_wr_idx;
  logic [cbm_pkg::CHR_FULL_W-1:0] chr_old;
  logic [cbm_pkg::CHR_FULL_W-1:0] chr_new;
  logic        reg_wr;
  logic        prg_we;
  logic        mir_we;
  logic        swap_we;
  logic        chr_we;

  always_comb begin
    top        = s1_addr_r[15:12];
    sel_byte   = s1_addr_r[7:0];
    s0         = sel_byte[sel0_r];
    s1         = sel_byte[sel1_r];
    mir_sel    = {s1, s0} & {2{variant_r}};
    chr_rel    = s1_addr_r - cbm_pkg::CHR_WIN_BASE;
    chr_wr_idx = {chr_rel[13:12], s1};
    chr_old    = cbm_pkg::CHR_FULL_W'(chr_r[chr_wr_idx]);
    if (s0) begin
      chr_new = {s1_data_r, chr_old[3:0]};
    end else begin
      chr_new = {chr_old[11:4], s1_data_r[3:0]};
    end
    reg_wr  = s1_fire && (s1_cmd_r == cbm_pkg::CMD_REG_WRITE);
    prg_we  = reg_wr && (top inside {cbm_pkg::TOP_PRG0, cbm_pkg::TOP_PRG1});
    mir_we  = reg_wr && (top == cbm_pkg::TOP_MIRROR) && !mir_sel[1]
              && (s1_data_r != cbm_pkg::DATA_NO_MIRROR);
    swap_we = reg_wr && (top == cbm_pkg::TOP_MIRROR) && (mir_sel == cbm_pkg::SEL_SWAP);
    chr_we  = reg_wr
              && (s1_addr_r inside {[cbm_pkg::CHR_WIN_BASE:cbm_pkg::CHR_WIN_LAST]});
  end

  // Mapper state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_r[0] <= PRG_REG_W'(0);
      prg_r[1] <= PRG_REG_W'(1);
      for (int i = 0; i < 8; i++) begin
        chr_r[i] <= CHR_BANK_BITS'(i);
      end
      swap_r   <= 1'b0;
      mirror_r <= 2'd0;
      latch_r  <= 1'b0;
    end else begin
      if (prg_we) begin
        prg_r[s1_addr_r[13]] <= PRG_REG_W'(s1_data_r[4:0]);
      end
      if (mir_we) begin
        mirror_r <= s1_data_r[1:0];
      end
      if (swap_we) begin
        swap_r <= s1_data_r[1];
      end
      if (chr_we) begin
        chr_r[chr_wr_idx] <= CHR_BANK_BITS'(chr_new);
      end
      if (s1_fire && (s1_cmd_r == cbm_pkg::CMD_LATCH_WRITE)) begin
        latch_r <= s1_data_r[0];
      end
    end
  end

  // Lookup translation
  logic [cbm_pkg::BANK_W-1:0]     bank_nxt;
  logic [cbm_pkg::OFFSET_W-1:0]   offset_nxt;
  logic [7:0]                     rdata_nxt;
  logic [cbm_pkg::CHR_FULL_W-1:0] chr_rd;
  cbm_pkg::mirror_t               nt_mode;

  always_comb begin
    bank_nxt   = '0;
    offset_nxt = '0;
    rdata_nxt  = '0;
    chr_rd     = cbm_pkg::CHR_FULL_W'(chr_r[s1_addr_r[12:10]]);
    nt_mode    = cbm_pkg::mirror_t'(mirror_r & {variant_r, 1'b1});
    case (s1_cmd_r)
      cbm_pkg::CMD_PRG_LOOKUP: begin
        case (s1_addr_r[14:13])
          2'd0:    bank_nxt = swap_r ? PRG_PENULT : cbm_pkg::BANK_W'(prg_r[0]);
          2'd1:    bank_nxt = cbm_pkg::BANK_W'(prg_r[1]);
          2'd2:    bank_nxt = swap_r ? cbm_pkg::BANK_W'(prg_r[0]) : PRG_PENULT;
          default: bank_nxt = PRG_LAST;
        endcase
        offset_nxt = s1_addr_r[12:0];
      end
      cbm_pkg::CMD_CHR_LOOKUP: begin
        bank_nxt   = chr_rd[cbm_pkg::BANK_W-1:0];
        offset_nxt = cbm_pkg::OFFSET_W'(s1_addr_r[9:0]);
      end
      cbm_pkg::CMD_NT_LOOKUP: begin
        case (nt_mode)
          cbm_pkg::MIR_VERTICAL:   bank_nxt = cbm_pkg::BANK_W'(s1_addr_r[10]);
          cbm_pkg::MIR_HORIZONTAL: bank_nxt = cbm_pkg::BANK_W'(s1_addr_r[11]);
          cbm_pkg::MIR_SINGLE_LOW: bank_nxt = '0;
          default:                 bank_nxt = cbm_pkg::BANK_W'(1);
        endcase
        offset_nxt = cbm_pkg::OFFSET_W'(s1_addr_r[9:0]);
      end
      cbm_pkg::CMD_LATCH_READ: begin
        rdata_nxt = {s1_data_r[7:1], latch_r};
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_bank_r   <= bank_nxt;
      out_offset_r <= offset_nxt;
      out_rdata_r  <= rdata_nxt;
    end
  end

  // Checks
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled without a held transaction");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("transaction left input register without a result");

  a_latch_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_cmd_r == cbm_pkg::CMD_LATCH_WRITE)) |=> (latch_r == $past(s1_data_r[0])))
    else $error("latch write lost");

  a_swap_needs_variant: assert property (@(posedge clk) disable iff (!rst_n)
    (reg_wr && !variant_r) |=> $stable(swap_r))
    else $error("swap mode written on the two-select board");

endmodule
